FILE: rtl/core/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg: shared constants and types for the AABB frustum cull test
// Chunk geometry, fixed-point widths and the per-plane term bundle that
// travels from the plane/product stage to the sign-test stage.
// ----------------------------------------------------------------------------
package afc_pkg;

  // chunk geometry
  localparam int CHUNK_WIDTH     = 16;
  localparam int CHUNK_TALL      = 64;
  localparam int VOXEL_SCALE_Q16 = 65536;

  localparam int NUM_ELEM   = 16;
  localparam int NUM_COLS   = 4;
  localparam int NUM_PLANES = 6;
  localparam int ROW3_BASE  = 12;

  localparam int EW   = 32;           // matrix element, Q16.16
  localparam int IDXW = 4;            // element index
  localparam int CW   = 16;           // chunk grid coordinate
  localparam int PW   = EW + 1;       // plane component, exact sum of two elements
  localparam int KW   = CW + 1;       // 2*c+1
  localparam int PRW  = PW + KW;      // component times 2*c+1
  localparam int MW   = PW + 1;       // magnitude of a component, kept signed
  localparam int SW   = PRW + 2;      // sum of two products and two magnitudes
  localparam int YW   = MW + 1;       // ny + |ny|
  localparam int AW   = SW + $clog2(CHUNK_WIDTH) + $clog2(CHUNK_TALL) + 2;
  localparam int TW   = AW + $clog2(VOXEL_SCALE_Q16) + 2;

  // d is Q16.16; the doubled test value is in units of 2^-32
  localparam int D_SHIFT = 17;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TEST = 1'b1
  } kind_t;

  typedef struct packed {
    logic signed [PRW-1:0] px;
    logic signed [PRW-1:0] pz;
    logic signed [MW-1:0]  mx;
    logic signed [MW-1:0]  mz;
    logic signed [MW-1:0]  my;
    logic signed [PW-1:0]  ny;
    logic signed [PW-1:0]  d;
  } plane_terms_t;

endpackage

FILE: rtl/core/aabb_frustum_cull_test.sv
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test: chunk box versus view frustum
// Holds a 4x4 Q16.16 view-projection matrix loaded one element per transfer
// and reports, per test transfer, whether the chunk column box can be seen.
// ----------------------------------------------------------------------------
// Pipeline: a test passes the input register, the plane/product register
//   and the result register, in that order, before its result shows on out_*.
// Throughput: one item per cycle while out_ready allows; the six planes run side by side, with the
//   twelve component products in the middle stage.
// Reset: synchronous active-low; clears all valid flags and the matrix to zero.
module aabb_frustum_cull_test (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic [afc_pkg::IDXW-1:0]          in_elem_index,
  input  logic signed [afc_pkg::EW-1:0]     in_elem_value,
  input  logic signed [afc_pkg::CW-1:0]     in_chunk_x,
  input  logic signed [afc_pkg::CW-1:0]     in_chunk_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_visible
);

  // input register
  logic                          in_v_r;
  afc_pkg::kind_t                in_kind_r;
  logic [afc_pkg::IDXW-1:0]      in_idx_r;
  logic signed [afc_pkg::EW-1:0] in_val_r;
  logic signed [afc_pkg::CW-1:0] in_cx_r;
  logic signed [afc_pkg::CW-1:0] in_cz_r;

  logic signed [afc_pkg::EW-1:0] mat_r [afc_pkg::NUM_ELEM];

  logic                  mid_v_r;
  afc_pkg::plane_terms_t terms_r   [afc_pkg::NUM_PLANES];
  afc_pkg::plane_terms_t terms_nxt [afc_pkg::NUM_PLANES];

  logic out_valid_r;
  logic out_visible_r;
  logic visible_nxt;

  logic out_load;
  logic mid_go;
  logic in_go;
  logic mat_we;

  logic signed [afc_pkg::PW-1:0] comp [afc_pkg::NUM_PLANES][afc_pkg::NUM_COLS];
  logic signed [afc_pkg::KW-1:0] kx;
  logic signed [afc_pkg::KW-1:0] kz;

  assign out_load = !out_valid_r || out_ready;
  assign mid_go   = !mid_v_r || out_load;
  assign in_go    = !in_v_r || mid_go;
  assign in_ready = in_go;

  // a load updates the matrix as it leaves the input register, in item order
  assign mat_we = in_v_r && (in_kind_r == afc_pkg::KIND_LOAD) && in_go;

  // 2*c+1
  assign kx = {in_cx_r, 1'b1};
  assign kz = {in_cz_r, 1'b1};

  // planes are row3 plus or minus row 0, 1, 2
  always_comb begin
    for (int k = 0; k < afc_pkg::NUM_PLANES; k++) begin
      for (int c = 0; c < afc_pkg::NUM_COLS; c++) begin
        if ((k % 2) == 1) begin
          comp[k][c] = afc_pkg::PW'(mat_r[afc_pkg::ROW3_BASE + c])
                     - afc_pkg::PW'(mat_r[(k / 2) * afc_pkg::NUM_COLS + c]);
        end else begin
          comp[k][c] = afc_pkg::PW'(mat_r[afc_pkg::ROW3_BASE + c])
                     + afc_pkg::PW'(mat_r[(k / 2) * afc_pkg::NUM_COLS + c]);
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < afc_pkg::NUM_PLANES; k++) begin
      terms_nxt[k].px = afc_pkg::PRW'(comp[k][0]) * afc_pkg::PRW'(kx);
      terms_nxt[k].pz = afc_pkg::PRW'(comp[k][2]) * afc_pkg::PRW'(kz);
      terms_nxt[k].mx = comp[k][0][afc_pkg::PW-1] ? -afc_pkg::MW'(comp[k][0])
                                                  : afc_pkg::MW'(comp[k][0]);
      terms_nxt[k].mz = comp[k][2][afc_pkg::PW-1] ? -afc_pkg::MW'(comp[k][2])
                                                  : afc_pkg::MW'(comp[k][2]);
      terms_nxt[k].my = comp[k][1][afc_pkg::PW-1] ? -afc_pkg::MW'(comp[k][1])
                                                  : afc_pkg::MW'(comp[k][1]);
      terms_nxt[k].ny = comp[k][1];
      terms_nxt[k].d  = comp[k][3];
    end
  end

  // culled when some plane gives a negative center distance plus radius
  always_comb begin
    logic signed [afc_pkg::SW-1:0] sx;
    logic signed [afc_pkg::YW-1:0] ys;
    logic signed [afc_pkg::AW-1:0] av;
    logic signed [afc_pkg::TW-1:0] tv;
    logic                          culled;
    culled = 1'b0;
    for (int k = 0; k < afc_pkg::NUM_PLANES; k++) begin
      sx = afc_pkg::SW'(terms_r[k].px) + afc_pkg::SW'(terms_r[k].mx)
         + afc_pkg::SW'(terms_r[k].pz) + afc_pkg::SW'(terms_r[k].mz);
      ys = afc_pkg::YW'(terms_r[k].ny) + afc_pkg::YW'(terms_r[k].my);
      av = afc_pkg::AW'(sx) * afc_pkg::AW'(afc_pkg::CHUNK_WIDTH)
         + afc_pkg::AW'(ys) * afc_pkg::AW'(afc_pkg::CHUNK_TALL);
      tv = afc_pkg::TW'(av) * afc_pkg::TW'(afc_pkg::VOXEL_SCALE_Q16)
         + (afc_pkg::TW'(terms_r[k].d) <<< afc_pkg::D_SHIFT);
      culled = culled | tv[afc_pkg::TW-1];
    end
    visible_nxt = !culled;
  end

  // input register: payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_go) begin
      in_v_r <= in_valid;
    end
    if (in_go) begin
      in_kind_r <= afc_pkg::kind_t'(in_kind);
      in_idx_r  <= in_elem_index;
      in_val_r  <= in_elem_value;
      in_cx_r   <= in_chunk_x;
      in_cz_r   <= in_chunk_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < afc_pkg::NUM_ELEM; i++) begin
        mat_r[i] <= '0;
      end
    end else if (mat_we) begin
      mat_r[in_idx_r] <= in_val_r;
    end
  end

  // loads drop out here; only tests advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_v_r <= 1'b0;
    end else if (mid_go) begin
      mid_v_r <= in_v_r && (in_kind_r == afc_pkg::KIND_TEST);
    end
    if (mid_go) begin
      for (int k = 0; k < afc_pkg::NUM_PLANES; k++) begin
        terms_r[k] <= terms_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= mid_v_r;
    end
    if (out_load) begin
      out_visible_r <= visible_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && (in_kind_r == afc_pkg::KIND_LOAD) && in_go) |=> !mid_v_r)
    else $error("load transfer produced a result");

  a_test_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_v_r && mid_go) |=> out_valid_r)
    else $error("test lost between middle and result stage");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_v_r && mid_v_r && out_valid_r && !out_ready))
    else $error("input stalled with a free stage");

  a_matrix_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !mat_we |=> $stable(mat_r[afc_pkg::ROW3_BASE + 3]))
    else $error("matrix changed without a load");

endmodule

FILE: test/aabb_frustum_cull_test_checker.sv
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test_checker: visibility scoreboard for the cull test
// Tracks the matrix loads seen on the input channel. For each accepted chunk
// test it computes the six-plane box test in wide exact integers, then checks
// every output transfer in order against those predictions.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_test_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_kind,
  input  logic [afc_pkg::IDXW-1:0]      in_elem_index,
  input  logic signed [afc_pkg::EW-1:0] in_elem_value,
  input  logic signed [afc_pkg::CW-1:0] in_chunk_x,
  input  logic signed [afc_pkg::CW-1:0] in_chunk_z,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_visible,
  output int                            fail_count,
  output int                            pending,
  output int                            visible_count,
  output int                            culled_count
);

  localparam int WIDE     = 128;
  localparam int D_WEIGHT = 131072;  // doubled Q16.16 d, in units of 2^-32

  typedef struct {
    logic signed [afc_pkg::CW-1:0] cx;
    logic signed [afc_pkg::CW-1:0] cz;
    logic                          visible;
  } verdict_t;

  logic [afc_pkg::EW-1:0] view_proj [afc_pkg::NUM_ELEM];
  verdict_t               verdict_q [$];

  function automatic logic box_in_frustum(input logic signed [afc_pkg::CW-1:0] cx,
                                          input logic signed [afc_pkg::CW-1:0] cz);
    logic signed [WIDE-1:0] m [afc_pkg::NUM_ELEM];
    logic signed [WIDE-1:0] kx, kz, nx, ny, nz, d, span, total;
    int   e;
    int   p;
    int   axis;
    int   r3;
    logic in_view;
    in_view = 1'b1;
    r3      = afc_pkg::ROW3_BASE;
    for (e = 0; e < afc_pkg::NUM_ELEM; e++) m[e] = WIDE'($signed(view_proj[e]));
    // box corners folded into 2c+1 so the half-extents stay integral
    kx = WIDE'(cx);
    kz = WIDE'(cz);
    kx = 2 * kx + 1;
    kz = 2 * kz + 1;
    for (p = 0; p < afc_pkg::NUM_PLANES; p++) begin
      axis = (p / 2) * afc_pkg::NUM_COLS;
      if (p % 2 == 0) begin
        nx = m[r3]     + m[axis];
        ny = m[r3 + 1] + m[axis + 1];
        nz = m[r3 + 2] + m[axis + 2];
        d  = m[r3 + 3] + m[axis + 3];
      end else begin
        nx = m[r3]     - m[axis];
        ny = m[r3 + 1] - m[axis + 1];
        nz = m[r3 + 2] - m[axis + 2];
        d  = m[r3 + 3] - m[axis + 3];
      end
      span = afc_pkg::CHUNK_WIDTH
             * (nx * kx + (nx < 0 ? -nx : nx) + nz * kz + (nz < 0 ? -nz : nz))
           + afc_pkg::CHUNK_TALL * (ny + (ny < 0 ? -ny : ny));
      total = afc_pkg::VOXEL_SCALE_Q16 * span + D_WEIGHT * d;
      if (total < 0) in_view = 1'b0;
    end
    return in_view;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t want;
    int       e;
    if (!rst_n) begin
      for (e = 0; e < afc_pkg::NUM_ELEM; e++) view_proj[e] = '0;
      verdict_q.delete();
      fail_count    = 0;
      pending       = 0;
      visible_count = 0;
      culled_count  = 0;
    end else begin
      // check the result first: a test accepted on this edge is never due yet
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected, visible=%0b",
                   $time, out_visible);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_visible !== want.visible) begin
            $display("%0t: chunk (%0d,%0d) visible: expected %0b, actual %0b",
                     $time, want.cx, want.cz, want.visible, out_visible);
            fail_count++;
          end
        end
        if (out_visible) visible_count++;
        else             culled_count++;
      end
      if (in_valid && in_ready) begin
        if (in_kind == afc_pkg::KIND_TEST) begin
          want.cx      = in_chunk_x;
          want.cz      = in_chunk_z;
          want.visible = box_in_frustum(in_chunk_x, in_chunk_z);
          verdict_q.insert(verdict_q.size(), want);
        end else begin
          view_proj[in_elem_index] = in_elem_value;
        end
      end
      pending = verdict_q.size();
    end
  end

endmodule

FILE: test/aabb_frustum_cull_test_tb.sv
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test_tb: stimulus and verdict for the frustum cull block
// Drives matrix loads and chunk tests with random gaps and output stalls,
// including a long output hold-off and a full drain pause; the checker
// beside the block predicts and compares every visibility result.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_test_tb;

  localparam int IDLE_PCT       = 9;
  localparam int HOLD_LEN       = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET    = 1550;
  localparam int DRAIN_CYCLES   = 10;
  localparam int HOLD_FRAME     = 3;
  localparam int PAUSE_FRAME    = 6;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic                          in_kind;
  logic [afc_pkg::IDXW-1:0]      in_elem_index;
  logic signed [afc_pkg::EW-1:0] in_elem_value;
  logic signed [afc_pkg::CW-1:0] in_chunk_x;
  logic signed [afc_pkg::CW-1:0] in_chunk_z;
  logic                          out_valid;
  logic                          out_ready;
  logic                          out_visible;

  int fail_count;
  int pending;
  int visible_count;
  int culled_count;
  int load_count;
  int test_count;
  int hold_asks;
  int idle_cycles;
  bit no_idle;

  aabb_frustum_cull_test i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_elem_index (in_elem_index),
    .in_elem_value (in_elem_value),
    .in_chunk_x    (in_chunk_x),
    .in_chunk_z    (in_chunk_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_visible   (out_visible)
  );

  aabb_frustum_cull_test_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_elem_index (in_elem_index),
    .in_elem_value (in_elem_value),
    .in_chunk_x    (in_chunk_x),
    .in_chunk_z    (in_chunk_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_visible   (out_visible),
    .fail_count    (fail_count),
    .pending       (pending),
    .visible_count (visible_count),
    .culled_count  (culled_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // one transfer; returns at the falling edge after acceptance
  task automatic send_item(input logic kind, input logic [afc_pkg::IDXW-1:0] idx,
                           input logic signed [afc_pkg::EW-1:0] val,
                           input logic signed [afc_pkg::CW-1:0] cx,
                           input logic signed [afc_pkg::CW-1:0] cz);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_elem_index <= idx;
    in_elem_value <= val;
    in_chunk_x    <= cx;
    in_chunk_z    <= cz;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic load_elem(input logic [afc_pkg::IDXW-1:0] idx,
                           input logic signed [afc_pkg::EW-1:0] val);
    send_item(afc_pkg::KIND_LOAD, idx, val, afc_pkg::CW'($urandom), afc_pkg::CW'($urandom));
    load_count++;
  endtask

  task automatic test_chunk(input logic signed [afc_pkg::CW-1:0] cx,
                            input logic signed [afc_pkg::CW-1:0] cz);
    send_item(afc_pkg::KIND_TEST, afc_pkg::IDXW'($urandom), afc_pkg::EW'($urandom), cx, cz);
    test_count++;
  endtask

  // random element from -2^shift up to 2^shift-1
  function automatic logic signed [afc_pkg::EW-1:0] rand_elem(input int shift);
    logic signed [afc_pkg::EW-1:0] r;
    r = $urandom;
    return r >>> (afc_pkg::EW - 1 - shift);
  endfunction

  // mostly chunks near the origin, some far out, a few anywhere
  function automatic logic signed [afc_pkg::CW-1:0] rand_coord();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60)      return afc_pkg::CW'($urandom_range(0, 32) - 16);
    else if (sel < 85) return afc_pkg::CW'($urandom_range(0, 1024) - 512);
    else               return afc_pkg::CW'($urandom);
  endfunction

  initial begin : receiver
    int hold_served;
    int n;
    hold_served = 0;
    out_ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_served) begin
        // hold off long enough for the pipe to fill and stall the input
        hold_served++;
        out_ready <= 1'b0;
        for (n = 1; n < HOLD_LEN; n++) @(negedge clk);
      end else begin
        out_ready <= no_idle || $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int                       frame;
    int                       k;
    int                       n_tests;
    int                       start;
    int                       step;
    int                       shift;
    int                       shift3;
    logic [afc_pkg::IDXW-1:0] idx;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = afc_pkg::KIND_LOAD;
    in_elem_index = '0;
    in_elem_value = '0;
    in_chunk_x    = '0;
    in_chunk_z    = '0;
    no_idle       = 1'b0;
    hold_asks     = 0;
    load_count    = 0;
    test_count    = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // all-zero matrix: every test value is zero, so always visible
    test_chunk(0, 0);
    test_chunk(-32768, 32767);
    // zero normals, d = -1.0 on every plane: culled on d alone
    load_elem(15, -65536);
    test_chunk(0, 0);
    load_elem(15, 32'sh7FFF_FFFF);
    test_chunk(-32768, -32768);
    load_elem(0, 32'sh8000_0000);
    test_chunk(32767, 0);
    test_chunk(-32768, 0);
    load_elem(5, 32'sh7FFF_FFFF);
    load_elem(10, 32'sh8000_0000);
    load_elem(12, 32'sh7FFF_FFFF);
    load_elem(14, 32'sh8000_0000);
    test_chunk(32767, 32767);
    test_chunk(-32768, -32768);
    test_chunk(0, -1);
    load_elem(15, 32'sh8000_0000);
    test_chunk(0, 0);
    test_chunk(-1, 32767);

    frame = 0;
    while (load_count + test_count < ITEM_TARGET) begin
      no_idle = (frame >= 8 && frame < 12);
      if (frame == PAUSE_FRAME) begin
        // drain everything before the next matrix
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      shift  = $urandom_range(8, 31);
      shift3 = $urandom_range(8, 31);
      start  = $urandom_range(0, afc_pkg::NUM_ELEM - 1);
      step   = 2 * $urandom_range(0, 7) + 1;
      for (k = 0; k < afc_pkg::NUM_ELEM; k++) begin
        idx = afc_pkg::IDXW'((start + k * step) % afc_pkg::NUM_ELEM);
        load_elem(idx, rand_elem(idx >= afc_pkg::ROW3_BASE ? shift3 : shift));
      end
      n_tests = (frame == HOLD_FRAME) ? 60 : $urandom_range(15, 50);
      if (frame == HOLD_FRAME) hold_asks++;
      for (k = 0; k < n_tests; k++) begin
        if ($urandom_range(0, 99) < 8)
          load_elem(afc_pkg::IDXW'($urandom_range(0, afc_pkg::NUM_ELEM - 1)),
                    rand_elem($urandom_range(0, 31)));
        test_chunk(rand_coord(), rand_coord());
      end
      frame++;
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d element loads over %0d random matrices and %0d chunk tests",
             load_count, frame, test_count);
    $display("  (%0d visible, %0d culled), with an output hold-off and a drain pause",
             visible_count, culled_count);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/afc_pkg.sv
rtl/core/aabb_frustum_cull_test.sv
test/aabb_frustum_cull_test_checker.sv
test/aabb_frustum_cull_test_tb.sv
